>>> design/clfd_pkg.sv
`timescale 1ns / 1ps

package clfd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;
    localparam int MIN_FRAME_BYTES = 7;

    localparam logic [7:0]  HEADER_BYTE = 8'h3A;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_EMPTY    = 3'd1;
    localparam logic [2:0] KIND_BAD_SIZE = 3'd2;
    localparam logic [2:0] KIND_BAD_CRC  = 3'd3;
    localparam logic [2:0] KIND_STRAY    = 3'd4;

    // For a data command, arg holds the payload length; for a stray byte, the byte.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] frame_type;
        logic [7:0]  arg;
    } cmd_t;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> design/crc16_length_framed_deframer.sv
`timescale 1ns / 1ps

// Channel   Handshake           Fields
// input     push / full         rx_byte[7:0]
// result    empty / pop         kind[2:0], frame_type[15:0], payload_byte[7:0], last
//
// A received byte is taken while push is high and full is low. A status result reaches
// the output register through a two-entry command queue, and later while the output
// register is held by a stalled result. A good frame is replayed from the payload memory
// byte by byte, each byte passing through the registered memory read and then the output
// register. Input is held off (full high) while the command queue is full, and from the
// end of a good frame with a payload until its last payload byte is loaded. Reset clears
// all control state; the payload memory is not cleared.

module crc16_length_framed_deframer
    import clfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  kind,
    output logic [15:0] frame_type,
    output logic [7:0]  payload_byte,
    output logic        last
);

    localparam int DEPTH = MAX_FRAME_BYTES - MIN_FRAME_BYTES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          cmd_push;
    cmd_t          cmd_in;
    logic          cmd_ready;
    logic          cmd_valid;
    cmd_t          cmd_out;
    logic          cmd_pop;
    logic          replay_done;
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;

    clfd_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
        .AW(AW)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .cmd_push(cmd_push),
        .cmd(cmd_in),
        .cmd_ready(cmd_ready),
        .replay_done(replay_done),
        .mem_we(mem_we),
        .mem_addr(mem_addr),
        .mem_wdata(mem_wdata)
    );

    clfd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(cmd_push),
        .wr_cmd(cmd_in),
        .wr_ready(cmd_ready),
        .rd_valid(cmd_valid),
        .rd_cmd(cmd_out),
        .rd_en(cmd_pop)
    );

    clfd_back #(
        .DEPTH(DEPTH),
        .AW(AW)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd(cmd_out),
        .cmd_pop(cmd_pop),
        .replay_done(replay_done),
        .mem_we(mem_we),
        .mem_addr(mem_addr),
        .mem_wdata(mem_wdata),
        .empty(empty),
        .pop(pop),
        .kind(kind),
        .frame_type(frame_type),
        .payload_byte(payload_byte),
        .last(last)
    );

endmodule

>>> design/clfd_front.sv
`timescale 1ns / 1ps

module clfd_front
    import clfd_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  logic [7:0]    rx_byte,
    output logic          cmd_push,
    output cmd_t          cmd,
    input  logic          cmd_ready,
    input  logic          replay_done,
    output logic          mem_we,
    output logic [AW-1:0] mem_addr,
    output logic [7:0]    mem_wdata
);

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_SIZE_LO = 4'b0010,
        PH_SIZE_HI = 4'b0100,
        PH_BODY    = 4'b1000
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        size_lo_reg, size_lo_next;
    logic [LEN_W-1:0]  frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]  count_reg, count_next;
    logic [15:0]       type_reg, type_next;
    logic [15:0]       crc_reg, crc_next;
    logic              replay_pend_reg, replay_pend_next;

    logic              accept;
    logic [15:0]       crc_fed;
    logic [15:0]       size_full;
    logic [LEN_W-1:0]  tail;
    logic [LEN_W-1:0]  count_inc;
    logic [LEN_W-1:0]  store_index;
    logic [LEN_W-1:0]  payload_len;

    assign full = !cmd_ready || replay_pend_reg;
    assign accept = push && !full;
    assign crc_fed = crc16_feed(crc_reg, rx_byte);
    assign size_full = {rx_byte, size_lo_reg};
    assign tail = frame_len_reg - LEN_W'(3);
    assign count_inc = count_reg + LEN_W'(1);
    assign store_index = count_reg - LEN_W'(2);
    assign payload_len = frame_len_reg - LEN_W'(MIN_FRAME_BYTES);

    assign mem_addr = store_index[AW-1:0];
    assign mem_wdata = rx_byte;

    always_comb
    begin
        phase_next = phase_reg;
        size_lo_next = size_lo_reg;
        frame_len_next = frame_len_reg;
        count_next = count_reg;
        type_next = type_reg;
        crc_next = crc_reg;
        replay_pend_next = replay_pend_reg;
        cmd_push = 1'b0;
        cmd = '0;
        mem_we = 1'b0;
        if (replay_done)
        begin
            replay_pend_next = 1'b0;
        end
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == HEADER_BYTE)
                    begin
                        crc_next = crc16_feed(CRC_INIT, rx_byte);
                        phase_next = PH_SIZE_LO;
                    end
                    else
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = KIND_STRAY;
                        cmd.arg = rx_byte;
                    end
                end
                PH_SIZE_LO:
                begin
                    crc_next = crc_fed;
                    size_lo_next = rx_byte;
                    phase_next = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    crc_next = crc_fed;
                    if (size_full < 16'(MIN_FRAME_BYTES) || size_full > 16'(MAX_FRAME_BYTES))
                    begin
                        cmd_push = 1'b1;
                        cmd.kind = KIND_BAD_SIZE;
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        frame_len_next = size_full[LEN_W-1:0];
                        count_next = '0;
                        type_next = '0;
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    crc_next = crc_fed;
                    count_next = count_inc;
                    if (count_reg == LEN_W'(0))
                    begin
                        type_next[7:0] = rx_byte;
                    end
                    else if (count_reg == LEN_W'(1))
                    begin
                        type_next[15:8] = rx_byte;
                    end
                    else if (count_reg < tail - LEN_W'(2))
                    begin
                        mem_we = 1'b1;
                    end
                    if (count_inc == tail)
                    begin
                        phase_next = PH_HUNT;
                        cmd_push = 1'b1;
                        if (crc_fed != 16'h0000)
                        begin
                            cmd.kind = KIND_BAD_CRC;
                        end
                        else if (payload_len == LEN_W'(0))
                        begin
                            cmd.kind = KIND_EMPTY;
                            cmd.frame_type = type_reg;
                        end
                        else
                        begin
                            cmd.kind = KIND_DATA;
                            cmd.frame_type = type_reg;
                            cmd.arg = 8'(payload_len);
                            replay_pend_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            size_lo_reg <= '0;
            frame_len_reg <= '0;
            count_reg <= '0;
            type_reg <= '0;
            crc_reg <= CRC_INIT;
            replay_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            size_lo_reg <= size_lo_next;
            frame_len_reg <= frame_len_next;
            count_reg <= count_next;
            type_reg <= type_next;
            crc_reg <= crc_next;
            replay_pend_reg <= replay_pend_next;
        end
    end

endmodule

>>> design/clfd_queue.sv
`timescale 1ns / 1ps

module clfd_queue
    import clfd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic wr_ready,
    output logic rd_valid,
    output cmd_t rd_cmd,
    input  logic rd_en
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = count_reg != 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_cmd = entry_reg[rd_ptr_reg];
    assign do_wr = wr_en && wr_ready;
    assign do_rd = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_wr;
        rd_ptr_next = rd_ptr_reg ^ do_rd;
        count_next = count_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> design/clfd_back.sv
`timescale 1ns / 1ps

module clfd_back
    import clfd_pkg::*;
#(
    parameter int DEPTH = 57,
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  cmd_t          cmd,
    output logic          cmd_pop,
    output logic          replay_done,
    input  logic          mem_we,
    input  logic [AW-1:0] mem_addr,
    input  logic [7:0]    mem_wdata,
    output logic          empty,
    input  logic          pop,
    output logic [2:0]    kind,
    output logic [15:0]   frame_type,
    output logic [7:0]    payload_byte,
    output logic          last
);

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_READ = 3'b010,
        B_SEND = 3'b100
    } back_state_t;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;

    back_state_t   state_reg, state_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    len_reg, len_next;
    logic [15:0]   type_reg, type_next;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_kind_reg, out_kind_next;
    logic [15:0]   out_type_reg, out_type_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic          slot_free;
    logic          is_last;

    assign empty = !out_valid_reg;
    assign kind = out_kind_reg;
    assign frame_type = out_type_reg;
    assign payload_byte = out_byte_reg;
    assign last = out_last_reg;

    assign slot_free = !out_valid_reg || pop;
    assign is_last = 8'(idx_reg) == len_reg - 8'd1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[idx_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        len_next = len_reg;
        type_next = type_reg;
        out_valid_next = out_valid_reg && !pop;
        out_kind_next = out_kind_reg;
        out_type_next = out_type_reg;
        out_byte_next = out_byte_reg;
        out_last_next = out_last_reg;
        cmd_pop = 1'b0;
        replay_done = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == KIND_DATA)
                    begin
                        idx_next = '0;
                        len_next = cmd.arg;
                        type_next = cmd.frame_type;
                        state_next = B_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next = cmd.kind;
                        out_type_next = cmd.frame_type;
                        out_byte_next = (cmd.kind == KIND_STRAY) ? cmd.arg : 8'h00;
                        out_last_next = 1'b1;
                    end
                end
            end
            B_READ:
            begin
                state_next = B_SEND;
            end
            B_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next = KIND_DATA;
                    out_type_next = type_reg;
                    out_byte_next = rd_data_reg;
                    out_last_next = is_last;
                    if (is_last)
                    begin
                        replay_done = 1'b1;
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        state_next = B_READ;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        type_reg <= type_next;
        out_kind_reg <= out_kind_next;
        out_type_reg <= out_type_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> design/clfd_checker.sv
`timescale 1ns / 1ps

module clfd_checker
    import clfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  kind,
    input logic [15:0] frame_type,
    input logic [7:0]  payload_byte,
    input logic        last
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result withdrawn before it was taken");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(kind) && $stable(frame_type)
            && $stable(payload_byte) && $stable(last)))
        else $error("result changed while stalled");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && kind != KIND_DATA) |-> last)
        else $error("status item without last mark");

    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == KIND_BAD_SIZE || kind == KIND_BAD_CRC || kind == KIND_STRAY))
            |-> (frame_type == 16'h0000))
        else $error("status item carries a frame type");

    a_run_type: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && kind == KIND_DATA && !last) ##1 !empty |->
            (kind == KIND_DATA && frame_type == $past(frame_type)))
        else $error("payload run broken before its last item");

endmodule

bind crc16_length_framed_deframer clfd_checker u_clfd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .empty(empty),
    .pop(pop),
    .kind(kind),
    .frame_type(frame_type),
    .payload_byte(payload_byte),
    .last(last)
);
